// ----- design/wsp_pkg.sv -----
// Shared types and constants for the world-to-screen projection pipeline.
`timescale 1ns / 1ps
package wsp_pkg;

  localparam int PosW   = 24;
  localparam int CoefW  = 16;
  localparam int RowW   = 64;
  localparam int DimW   = 14;
  localparam int ScrW   = 16;
  localparam int ProdW  = 40;
  localparam int ClipW  = 43;
  localparam int NdcW   = 44;
  localparam int HalfW  = 13;
  localparam int NumW   = 58;
  localparam int QuoW   = 17;
  localparam int DivStg = QuoW + 1;
  localparam int CfgIdxW = 3;

  // Smallest Q.20 clip w with 10*w >= 2^20.
  localparam logic signed [ClipW-1:0] WMin = 43'sd104858;

  localparam logic [CfgIdxW-1:0] CFG_ROW0   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW1   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW2   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROW3   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 3'd5;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [QuoW-1:0] q;
    logic            ovf;
    logic            neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        lx;
    div_lane_t        ly;
    logic [ClipW-1:0] d;
    logic             vis;
  } div_stage_t;

endpackage

// ----- design/wsp_if.sv -----
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface wsp_in_if;
  import wsp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  modport source(output valid, pos_x, pos_y, pos_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface wsp_out_if;
  import wsp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   visible;
  logic signed [ScrW-1:0] screen_x;
  logic signed [ScrW-1:0] screen_y;
  modport source(output valid, visible, screen_x, screen_y, input ready);
  modport sink(input valid, visible, screen_x, screen_y, output ready);
endinterface

// ----- design/wsp_div.sv -----
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps
module wsp_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s_valid,
  output logic                            s_ready,
  input  logic [wsp_pkg::NumW-1:0]        num_x,
  input  logic [wsp_pkg::NumW-1:0]        num_y,
  input  logic                            neg_x,
  input  logic                            neg_y,
  input  logic [wsp_pkg::ClipW-1:0]       div_d,
  input  logic                            vis,
  output logic                            m_valid,
  input  logic                            m_ready,
  output wsp_pkg::div_stage_t             m_data
);
  import wsp_pkg::*;

  logic       v_r  [DivStg];
  div_stage_t st_r [DivStg];
  logic       rdy  [DivStg+1];

  assign rdy[DivStg] = m_ready;
  assign s_ready     = rdy[0];
  assign m_valid     = v_r[DivStg-1];
  assign m_data      = st_r[DivStg-1];

  // entry: quotient of 2^17 or more is flagged as overflow
  logic [59:0] d_top;
  assign d_top = 60'(div_d) << QuoW;

  div_stage_t st0_nxt;

  always_comb begin
    st0_nxt        = '0;
    st0_nxt.lx.rem = num_x;
    st0_nxt.lx.ovf = 60'(num_x) >= d_top;
    st0_nxt.lx.neg = neg_x;
    st0_nxt.ly.rem = num_y;
    st0_nxt.ly.ovf = 60'(num_y) >= d_top;
    st0_nxt.ly.neg = neg_y;
    st0_nxt.d      = div_d;
    st0_nxt.vis    = vis;
  end

  assign rdy[0] = !v_r[0] || rdy[1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= s_valid;
    end
    if (rdy[0]) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar i = 1; i < DivStg; i++) begin : g_stage
    localparam int Sh = QuoW - i;
    logic [59:0] ds;
    logic [59:0] rx, ry;
    logic        bx, by;
    div_stage_t  st_nxt;
    assign ds = 60'(st_r[i-1].d) << Sh;
    assign rx = 60'(st_r[i-1].lx.rem);
    assign ry = 60'(st_r[i-1].ly.rem);
    assign bx = rx >= ds;
    assign by = ry >= ds;
    assign rdy[i] = !v_r[i] || rdy[i+1];

    always_comb begin
      st_nxt          = st_r[i-1];
      st_nxt.lx.rem   = bx ? NumW'(rx - ds) : st_r[i-1].lx.rem;
      st_nxt.lx.q[Sh] = bx;
      st_nxt.ly.rem   = by ? NumW'(ry - ds) : st_r[i-1].ly.rem;
      st_nxt.ly.q[Sh] = by;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= v_r[i-1];
      end
      if (rdy[i]) begin
        st_r[i] <= st_nxt;
      end
    end
  end

endmodule

// ----- design/world_to_screen_projection.sv -----
// Top level of the world-to-screen perspective projection pipeline.
`timescale 1ns / 1ps
// Usage:
//  - in_pt carries one world point request (pos_x, pos_y, pos_z, signed Q16.8);
//    it is taken at a clock edge with in_pt.valid and in_pt.ready high.
//  - out_res returns one result per request, in order: visible, screen_x,
//    screen_y (zero when clip w is below 0.1).
//  - cfg_we/cfg_idx/cfg_wdata write the matrix rows (0..3), viewport width (4)
//    and height (5); other indexes are ignored. Write only while idle.
//  - Pipeline: 26 register stages (7 transform and scaling stages, 18 divider
//    stages, 1 output register).
//  - Throughput: one request per cycle while out_res.ready is high; the 17-step
//    restoring divider is fully unrolled, one quotient bit per stage.
//  - Reset (rst_n low, synchronous) empties the pipeline and loads the identity
//    matrix and a 1920x1080 viewport.
//  - When out_res.ready is low, items close up behind the output register;
//    in_pt.ready falls only once every stage holds a request.
module world_to_screen_projection (
  input  logic                           clk,
  input  logic                           rst_n,
  wsp_in_if.sink                         in_pt,
  wsp_out_if.source                      out_res,
  input  logic                           cfg_we,
  input  logic [wsp_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [wsp_pkg::RowW-1:0]       cfg_wdata
);
  import wsp_pkg::*;

  // ---------------- configuration ----------------
  logic [RowW-1:0] row_r [4];
  logic [DimW-1:0] vw_r, vh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= 64'd4096;
      row_r[1] <= 64'd4096 << 16;
      row_r[2] <= 64'd4096 << 32;
      row_r[3] <= 64'd4096 << 48;
      vw_r     <= 14'd1920;
      vh_r     <= 14'd1080;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROW0:   row_r[0] <= cfg_wdata;
        CFG_ROW1:   row_r[1] <= cfg_wdata;
        CFG_ROW2:   row_r[2] <= cfg_wdata;
        CFG_ROW3:   row_r[3] <= cfg_wdata;
        CFG_WIDTH:  vw_r     <= cfg_wdata[DimW-1:0];
        CFG_HEIGHT: vh_r     <= cfg_wdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  logic [HalfW-1:0] hw, hh;
  assign hw = vw_r[DimW-1:1];
  assign hh = vh_r[DimW-1:1];

  function automatic logic signed [CoefW-1:0] coef(input logic [RowW-1:0] row, input int j);
    return $signed(row[16*j +: 16]);
  endfunction

  // ---------------- valid/ready chain ----------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdyo;
  logic div_s_ready, div_m_valid;
  div_stage_t div_out;

  assign rdyo = !vo_r || out_res.ready;
  assign rdy7 = !v7_r || div_s_ready;
  assign rdy6 = !v6_r || rdy7;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_pt.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, vo_r} <= '0;
    end else begin
      if (rdy1) v1_r <= in_pt.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
      if (rdyo) vo_r <= div_m_valid;
    end
  end

  // ---------------- stage 1: coefficient products ----------------
  // lanes 0, 1, 2 hold matrix rows 0, 1, 3 (cx, cy, cw)
  logic signed [ProdW-1:0] p_r  [3][3];
  logic signed [ClipW-1:0] ct_r [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    localparam int Rw = (r == 2) ? 3 : r;
    always_ff @(posedge clk) begin
      if (rdy1) begin
        p_r[r][0] <= in_pt.pos_x * coef(row_r[Rw], 0);
        p_r[r][1] <= in_pt.pos_y * coef(row_r[Rw], 1);
        p_r[r][2] <= in_pt.pos_z * coef(row_r[Rw], 2);
        ct_r[r]   <= ClipW'(coef(row_r[Rw], 3)) <<< 8;
      end
    end
  end

  // ---------------- stages 2, 3: dot product sums ----------------
  logic signed [ClipW-1:0] a_r [3];
  logic signed [ClipW-1:0] b_r [3];
  logic signed [ClipW-1:0] c_r [3];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      if (rdy2) begin
        a_r[r] <= ClipW'(p_r[r][0]) + ClipW'(p_r[r][1]);
        b_r[r] <= ClipW'(p_r[r][2]) + ct_r[r];
      end
      if (rdy3) c_r[r] <= a_r[r] + b_r[r];
    end
  end

  // ---------------- stage 4: visibility and NDC numerators ----------------
  logic signed [NdcW-1:0] nx_r, ny_r;
  logic [ClipW-1:0]       d4_r, d5_r, d6_r, d7_r;
  logic                   vis4_r, vis5_r, vis6_r, vis7_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      nx_r   <= NdcW'(c_r[2]) + NdcW'(c_r[0]);
      ny_r   <= NdcW'(c_r[2]) - NdcW'(c_r[1]);
      vis4_r <= c_r[2] >= WMin;
      d4_r   <= c_r[2];
    end
  end

  // ---------------- stage 5: sign and magnitude ----------------
  logic [NdcW-1:0] mx_r, my_r;
  logic            nx5_r, ny5_r, nx6_r, ny6_r, nx7_r, ny7_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      mx_r   <= nx_r[NdcW-1] ? NdcW'(-nx_r) : nx_r;
      my_r   <= ny_r[NdcW-1] ? NdcW'(-ny_r) : ny_r;
      nx5_r  <= nx_r[NdcW-1];
      ny5_r  <= ny_r[NdcW-1];
      vis5_r <= vis4_r;
      d5_r   <= d4_r;
    end
  end

  // ---------------- stage 6: viewport scale, split partial products ----------------
  logic [HalfW+21:0] xlo_r, xhi_r, ylo_r, yhi_r;

  always_ff @(posedge clk) begin
    if (rdy6) begin
      xlo_r  <= (HalfW+22)'(hw) * (HalfW+22)'(mx_r[21:0]);
      xhi_r  <= (HalfW+22)'(hw) * (HalfW+22)'(mx_r[43:22]);
      ylo_r  <= (HalfW+22)'(hh) * (HalfW+22)'(my_r[21:0]);
      yhi_r  <= (HalfW+22)'(hh) * (HalfW+22)'(my_r[43:22]);
      nx6_r  <= nx5_r;
      ny6_r  <= ny5_r;
      vis6_r <= vis5_r;
      d6_r   <= d5_r;
    end
  end

  // ---------------- stage 7: full dividends ----------------
  logic [NumW-1:0] numx_r, numy_r;

  always_ff @(posedge clk) begin
    if (rdy7) begin
      numx_r <= NumW'(xlo_r) + (NumW'(xhi_r) << 22);
      numy_r <= NumW'(ylo_r) + (NumW'(yhi_r) << 22);
      nx7_r  <= nx6_r;
      ny7_r  <= ny6_r;
      vis7_r <= vis6_r;
      d7_r   <= d6_r;
    end
  end

  // ---------------- divide by clip w ----------------
  wsp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (v7_r),
    .s_ready (div_s_ready),
    .num_x   (numx_r),
    .num_y   (numy_r),
    .neg_x   (nx7_r),
    .neg_y   (ny7_r),
    .div_d   (d7_r),
    .vis     (vis7_r),
    .m_valid (div_m_valid),
    .m_ready (rdyo),
    .m_data  (div_out)
  );

  // ---------------- output: sign, saturate, mask ----------------
  function automatic logic signed [ScrW-1:0] sat(input div_lane_t l);
    logic signed [QuoW:0] nq;
    nq = -$signed({1'b0, l.q});
    if (l.neg) begin
      if (l.ovf || l.q > 17'd32768) return 16'sh8000;
      return nq[ScrW-1:0];
    end
    if (l.ovf || l.q > 17'd32767) return 16'sh7FFF;
    return l.q[ScrW-1:0];
  endfunction

  logic                   vis_o_r;
  logic signed [ScrW-1:0] sx_o_r, sy_o_r;

  always_ff @(posedge clk) begin
    if (rdyo) begin
      vis_o_r <= div_out.vis;
      sx_o_r  <= div_out.vis ? sat(div_out.lx) : '0;
      sy_o_r  <= div_out.vis ? sat(div_out.ly) : '0;
    end
  end

  assign out_res.valid    = vo_r;
  assign out_res.visible  = vis_o_r;
  assign out_res.screen_x = sx_o_r;
  assign out_res.screen_y = sy_o_r;

  // ---------------- checks ----------------
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.visible |-> out_res.screen_x == 0 && out_res.screen_y == 0)
    else $error("hidden point with nonzero screen coordinates");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_res.valid |-> in_pt.ready)
    else $error("input stalled while output stage empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid)
    else $error("result valid right after reset");

endmodule

// ----- tb/world_to_screen_projection_test.sv -----
// Self-checking testbench for the world-to-screen projection pipeline.
`timescale 1ns / 1ps
module world_to_screen_projection_test;
  import wsp_pkg::*;

  typedef struct packed {
    logic                   vis;
    logic signed [ScrW-1:0] sx;
    logic signed [ScrW-1:0] sy;
  } screen_pt_t;

  localparam int CycleLimit = 2000000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx = CFG_ROW0;
  logic [RowW-1:0]       cfg_wdata = '0;

  wsp_in_if  in_pt();
  wsp_out_if out_res();

  world_to_screen_projection u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pt     (in_pt.sink),
    .out_res   (out_res.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Local copy of the block's registers, updated as writes go out.
  logic [RowW-1:0] mat_copy [4];
  logic [DimW-1:0] vw_copy;
  logic [DimW-1:0] vh_copy;

  screen_pt_t pending_pts[$];
  int         errors = 0;
  longint     cycles = 0;
  bit         quiet = 1'b0;   // no idling on either side when set
  bit         in_took = 1'b0;
  int         stall_left = 0;

  initial begin
    in_pt.valid   = 1'b0;
    in_pt.pos_x   = '0;
    in_pt.pos_y   = '0;
    in_pt.pos_z   = '0;
    out_res.ready = 1'b0;
  end

  // Projection predictor: clip coords in Q.20, then viewport mapping.
  function automatic longint clip_dot(logic [RowW-1:0] row, longint x, longint y,
                                      longint z);
    longint c0, c1, c2, c3;
    c0 = longint'($signed(row[15:0]));
    c1 = longint'($signed(row[31:16]));
    c2 = longint'($signed(row[47:32]));
    c3 = longint'($signed(row[63:48]));
    return x * c0 + y * c1 + z * c2 + c3 * 256;
  endfunction

  function automatic logic signed [ScrW-1:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[ScrW-1:0];
  endfunction

  function automatic screen_pt_t project_point(logic signed [PosW-1:0] px,
                                               logic signed [PosW-1:0] py,
                                               logic signed [PosW-1:0] pz);
    screen_pt_t r;
    longint x, y, z, cx, cy, cw, hw, hh;
    x  = px;
    y  = py;
    z  = pz;
    cx = clip_dot(mat_copy[0], x, y, z);
    cy = clip_dot(mat_copy[1], x, y, z);
    cw = clip_dot(mat_copy[3], x, y, z);
    hw = vw_copy / 2;
    hh = vh_copy / 2;
    r = '0;
    // Behind the near limit (w < 0.1): invisible, screen coords zero.
    if (cw * 10 < (64'sd1 <<< 20)) return r;
    r.vis = 1'b1;
    r.sx  = clamp16((hw * (cw + cx)) / cw);
    r.sy  = clamp16((hh * (cw - cy)) / cw);
    return r;
  endfunction

  // Request side: predict at acceptance; flag is read by the sender at negedge.
  always @(posedge clk) begin
    cycles  <= cycles + 1;
    in_took = 1'b0;
    if (rst_n && in_pt.valid && in_pt.ready) begin
      pending_pts.push_back(project_point(in_pt.pos_x, in_pt.pos_y, in_pt.pos_z));
      in_took = 1'b1;
    end
  end

  // Result side: compare against the oldest prediction.
  always @(posedge clk) begin
    screen_pt_t exp_pt;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected result vis=%0d x=%0d y=%0d", $time,
                 out_res.visible, out_res.screen_x, out_res.screen_y);
        errors++;
      end else begin
        exp_pt = pending_pts.pop_front();
        if (out_res.visible !== exp_pt.vis) begin
          $display("%0t: visible expected %0d actual %0d", $time, exp_pt.vis,
                   out_res.visible);
          errors++;
        end
        if (out_res.screen_x !== exp_pt.sx) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, exp_pt.sx,
                   out_res.screen_x);
          errors++;
        end
        if (out_res.screen_y !== exp_pt.sy) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, exp_pt.sy,
                   out_res.screen_y);
          errors++;
        end
      end
    end
  end

  // Result stalls: bursts of random length, none once quiet.
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (!quiet) begin
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
        rdy = 1'b0;
      end
    end
    out_res.ready <= rdy;
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sends one point request; entered and left at a falling edge.
  task automatic send_point(logic signed [PosW-1:0] px, logic signed [PosW-1:0] py,
                            logic signed [PosW-1:0] pz);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_pt.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pt.valid <= 1'b1;
    in_pt.pos_x <= px;
    in_pt.pos_y <= py;
    in_pt.pos_z <= pz;
    do @(negedge clk); while (!in_took);
  endtask

  // Drop valid and wait for the pipeline to empty.
  task automatic drain;
    in_pt.valid <= 1'b0;
    do @(negedge clk); while (pending_pts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Register write; only called while drained.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RowW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROW0, CFG_ROW1, CFG_ROW2, CFG_ROW3: mat_copy[idx[1:0]] = data;
      CFG_WIDTH:  vw_copy = data[DimW-1:0];
      CFG_HEIGHT: vh_copy = data[DimW-1:0];
      default: ;  // unknown index: ignored by the block
    endcase
    @(negedge clk);
  endtask

  function automatic logic [RowW-1:0] pack_row(int c0, int c1, int c2, int c3);
    return {c3[15:0], c2[15:0], c1[15:0], c0[15:0]};
  endfunction

  task automatic test_reset_defaults;
    send_point(24'sd0, 24'sd0, 24'sd0);
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_point(-24'sh800000, -24'sh800000, -24'sh800000);
    send_point(24'sd256, -24'sd256, 24'sd1000);
    send_point(24'sd128, 24'sd64, 24'sd0);
    drain();
  endtask

  // Near-limit edge: w = c*256 in Q.20, visible from c = 410 up.
  task automatic test_visibility_edge;
    write_reg(CFG_ROW0, pack_row(4096, 0, 0, 0));
    write_reg(CFG_ROW1, pack_row(0, 4096, 0, 0));
    write_reg(CFG_ROW2, pack_row(0, 0, 4096, 0));
    write_reg(CFG_ROW3, pack_row(0, 0, 0, 409));
    send_point(24'sd100, 24'sd100, 24'sd0);
    drain();
    write_reg(CFG_ROW3, pack_row(0, 0, 0, 410));
    send_point(24'sd100, 24'sd100, 24'sd0);
    send_point(-24'sd100, 24'sd5, 24'sd0);
    drain();
    // w from z: zero, negative and just across the limit
    write_reg(CFG_ROW3, pack_row(0, 0, 4096, 0));
    send_point(24'sd10, 24'sd10, 24'sd0);
    send_point(24'sd10, 24'sd10, -24'sd500);
    send_point(24'sd10, 24'sd10, 24'sd25);
    send_point(24'sd10, 24'sd10, 24'sd26);
    drain();
  endtask

  // Saturation: huge x, y against a tiny w.
  task automatic test_saturation;
    write_reg(CFG_ROW0, pack_row(32767, -32768, 0, 32767));
    write_reg(CFG_ROW1, pack_row(-32768, 32767, 0, -32768));
    write_reg(CFG_ROW3, pack_row(0, 0, 0, 410));
    send_point(24'sh7FFFFF, -24'sh800000, 24'sd0);
    send_point(-24'sh800000, 24'sh7FFFFF, 24'sd0);
    drain();
  endtask

  // Viewport sizes 0, 1, max, and upper bits dropped; unknown indexes ignored.
  task automatic test_viewport_sizes;
    write_reg(CFG_ROW0, pack_row(2048, 0, 0, 0));
    write_reg(CFG_ROW1, pack_row(0, 2048, 0, 0));
    write_reg(CFG_ROW3, pack_row(0, 0, 0, 4096));
    write_reg(CFG_WIDTH, 64'd0);
    write_reg(CFG_HEIGHT, 64'd1);
    send_point(24'sd256, 24'sd256, 24'sd0);
    drain();
    write_reg(CFG_WIDTH, 64'd16383);
    write_reg(CFG_HEIGHT, 64'hFFFF_FFFF_FFFF_C000 | 64'd8192);
    send_point(24'sd256, -24'sd256, 24'sd0);
    send_point(-24'sd512, 24'sd512, 24'sd0);
    drain();
    write_reg(3'd6, 64'd5);
    write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(24'sd100, 24'sd200, 24'sd300);
    drain();
  endtask

  function automatic int small_coef();
    return $urandom_range(0, 8191) - 4096;
  endfunction

  // Random phases: each has its own matrix and viewport.
  task automatic test_random_points;
    int n_phases, kind, mag;
    logic signed [PosW-1:0] px, py, pz;
    n_phases = 12;
    for (int ph = 0; ph < n_phases; ph++) begin
      quiet = (ph >= n_phases - 3);
      kind  = $urandom_range(0, 3);
      if (kind == 0) begin
        // raw random rows
        for (int r = 0; r < 4; r++)
          write_reg(r[CfgIdxW-1:0], {$urandom, $urandom});
      end else begin
        // camera-like: w mostly positive and grows with z
        write_reg(CFG_ROW0, pack_row(small_coef(), small_coef() / 8,
                                     small_coef() / 8, small_coef()));
        write_reg(CFG_ROW1, pack_row(small_coef() / 8, small_coef(),
                                     small_coef() / 8, small_coef()));
        write_reg(CFG_ROW2, {$urandom, $urandom});
        write_reg(CFG_ROW3, pack_row(small_coef() / 64, small_coef() / 64,
                                     $urandom_range(16, 4096),
                                     $urandom_range(0, 8192)));
      end
      write_reg(CFG_WIDTH, {$urandom, $urandom});
      write_reg(CFG_HEIGHT, 64'($urandom_range(1, 8192)));
      for (int i = 0; i < 100; i++) begin
        if (kind == 0 || $urandom_range(0, 4) == 0) begin
          px = PosW'($urandom);
          py = PosW'($urandom);
          pz = PosW'($urandom);
        end else begin
          mag = $urandom_range(4, 20);
          px = PosW'($signed($urandom) >>> (32 - mag));
          py = PosW'($signed($urandom) >>> (32 - mag));
          pz = PosW'($urandom_range(0, (1 << mag) - 1));
        end
        send_point(px, py, pz);
      end
      drain();
    end
  endtask

  initial begin
    mat_copy[0] = 64'd4096;
    mat_copy[1] = 64'd4096 << 16;
    mat_copy[2] = 64'd4096 << 32;
    mat_copy[3] = 64'd4096 << 48;
    vw_copy = 14'd1920;
    vh_copy = 14'd1080;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_visibility_edge();
    test_saturation();
    test_viewport_sizes();
    test_random_points();
    repeat (30) @(negedge clk);
    if (errors == 0 && pending_pts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
